// ===== design/tool_presence_and_fault_supervisor_defines.svh =====
// Assertion helpers shared by the checkers of the tool supervisor.
// They expect clk and arst_n in the scope where they are used.
`ifndef TOOL_PRESENCE_AND_FAULT_SUPERVISOR_DEFINES_SVH
`define TOOL_PRESENCE_AND_FAULT_SUPERVISOR_DEFINES_SVH

// Same-cycle implication.
`define TPFS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tool supervisor check failed");

// Next-cycle implication.
`define TPFS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tool supervisor check failed");

`endif

// ===== design/tpfs_pkg.sv =====
package tpfs_pkg;

	// Samples of the change pin beyond which the request asserts
	localparam int unsigned CHANGE_HOLD_COUNT = 5;

	localparam int unsigned IN_TDATA_W  = 32;
	localparam int unsigned OUT_TDATA_W = 8;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned CFG_DATA_W  = 16;

	localparam logic [15:0] TICKS_MAX = 16'hFFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEMP_HIGH    = 3'd0,
		REG_TEMP_ABSURD  = 3'd1,
		REG_TEMP_LOW     = 3'd2,
		REG_FAULT_TICKS  = 3'd3,
		REG_CURRENT_EN   = 3'd4,
		REG_CURRENT_A    = 3'd5,
		REG_CURRENT_B    = 3'd6
	} reg_index_t;

	typedef enum logic [2:0] {
		FAULT_OK           = 3'd0,
		FAULT_NO_TOOL      = 3'd1,
		FAULT_OVER_TEMP    = 3'd2,
		FAULT_LOW_TEMP     = 3'd3,
		FAULT_OVER_CURRENT = 3'd4
	} fault_code_t;

	typedef enum logic [1:0] {
		TOOL_NONE   = 2'd0,
		TOOL_TYPE_A = 2'd1,
		TOOL_TYPE_B = 2'd2
	} tool_type_t;

	typedef struct packed {
		logic [11:0] temp_high_limit;
		logic [11:0] temp_absurd_limit;
		logic [11:0] temp_low_limit;
		logic [15:0] fault_tick_limit;
		logic        current_check_enable;
		logic [11:0] current_limit_type_a;
		logic [11:0] current_limit_type_b;
	} cfg_t;

	typedef struct packed {
		logic        holder_pin;
		logic        type_pin_a;
		logic        type_pin_b;
		logic        change_pin;
		logic [11:0] temp_sample;
		logic [11:0] current_sample;
		logic        working_mode;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  lifted_count;
		logic [1:0]  resting_count;
		logic        docked_flag;
		logic        previous_docked;
		logic [2:0]  change_count;
		logic        change_flag;
		logic [15:0] fault_ticks;
		fault_code_t fault_state;
	} state_t;

	typedef struct packed {
		logic        tool_docked;
		tool_type_t  tool_type;
		logic        change_request;
		fault_code_t fault_code;
		logic        display_refresh_restart;
	} out_item_t;

endpackage

// ===== design/tpfs_step.sv =====
module tpfs_step (
	input  tpfs_pkg::state_t    st,
	input  tpfs_pkg::cfg_t      cfg,
	input  tpfs_pkg::in_item_t  item,
	output tpfs_pkg::state_t    nxt,
	output tpfs_pkg::out_item_t res
);

	tpfs_pkg::tool_type_t  tool_type;
	tpfs_pkg::fault_code_t fault;
	logic        pulse;
	logic        fault_cond;
	logic        temp_over;
	logic        temp_under;
	logic [3:0]  change_inc;
	logic [15:0] ticks_inc;

	// Decode the tool type from the identification pins
	always_comb begin
		if (item.type_pin_a && !item.type_pin_b) begin
			tool_type = tpfs_pkg::TOOL_TYPE_A;
		end else if (!item.type_pin_a && item.type_pin_b) begin
			tool_type = tpfs_pkg::TOOL_TYPE_B;
		end else begin
			tool_type = tpfs_pkg::TOOL_NONE;
		end
	end

	assign temp_over  = item.temp_sample > cfg.temp_high_limit;
	assign temp_under = item.temp_sample < cfg.temp_low_limit;
	assign fault_cond = item.working_mode
		&& (temp_over || temp_under || tool_type == tpfs_pkg::TOOL_NONE);
	assign change_inc = {1'b0, st.change_count} + 4'd1;
	assign ticks_inc  = (st.fault_ticks != tpfs_pkg::TICKS_MAX) ?
		st.fault_ticks + 16'd1 : st.fault_ticks;

	always_comb begin
		nxt   = st;
		pulse = 1'b0;

		// Debounce the holder pin: two equal samples move the position
		if (item.holder_pin) begin
			nxt.resting_count = 2'd0;
			if (st.lifted_count != 2'd0) begin
				nxt.lifted_count    = 2'd0;
				nxt.docked_flag     = 1'b0;
				pulse               = st.previous_docked;
				nxt.previous_docked = 1'b0;
			end else begin
				nxt.lifted_count = 2'd1;
			end
		end else begin
			nxt.lifted_count = 2'd0;
			if (st.resting_count != 2'd0) begin
				nxt.resting_count   = 2'd0;
				nxt.docked_flag     = 1'b1;
				nxt.previous_docked = 1'b1;
			end else begin
				nxt.resting_count = 2'd1;
			end
		end

		// Count low samples of the change pin; the request holds until the pin rises
		if (!item.change_pin) begin
			if (change_inc > 4'(tpfs_pkg::CHANGE_HOLD_COUNT)) begin
				nxt.change_count = 3'd0;
				nxt.change_flag  = 1'b1;
			end else begin
				nxt.change_count = change_inc[2:0];
			end
		end else begin
			nxt.change_count = 3'd0;
			nxt.change_flag  = 1'b0;
		end

		// Advance the fault timer and classify once it reaches the limit
		fault = st.fault_state;
		if (fault_cond) begin
			nxt.fault_ticks = ticks_inc;
			if (ticks_inc >= cfg.fault_tick_limit) begin
				priority if (tool_type == tpfs_pkg::TOOL_NONE) begin
					fault = tpfs_pkg::FAULT_NO_TOOL;
				end else if (item.temp_sample > cfg.temp_absurd_limit) begin
					fault = tpfs_pkg::FAULT_NO_TOOL;
				end else if (temp_over && item.temp_sample < cfg.temp_absurd_limit) begin
					fault = tpfs_pkg::FAULT_OVER_TEMP;
				end else if (temp_under && !nxt.docked_flag
						&& st.fault_state != tpfs_pkg::FAULT_OVER_CURRENT) begin
					fault = tpfs_pkg::FAULT_LOW_TEMP;
				end else begin
					fault = st.fault_state;
				end
			end
		end else begin
			nxt.fault_ticks = 16'd0;
			if (st.fault_state != tpfs_pkg::FAULT_OVER_CURRENT) begin
				fault = tpfs_pkg::FAULT_OK;
			end
		end

		// Latch over-current; only a no-tool or over-temp fault can replace it
		if (cfg.current_check_enable) begin
			if ((tool_type == tpfs_pkg::TOOL_TYPE_A
					&& item.current_sample > cfg.current_limit_type_a)
					|| (tool_type == tpfs_pkg::TOOL_TYPE_B
					&& item.current_sample > cfg.current_limit_type_b)) begin
				fault = tpfs_pkg::FAULT_OVER_CURRENT;
			end
		end
		nxt.fault_state = fault;
	end

	assign res.tool_docked             = nxt.docked_flag;
	assign res.tool_type               = tool_type;
	assign res.change_request          = nxt.change_flag;
	assign res.fault_code              = fault;
	assign res.display_refresh_restart = pulse;

endmodule

// ===== design/tool_presence_and_fault_supervisor.sv =====
// Tool presence and fault supervisor.
// Each request on the s_axis channel is one supervision tick carrying the
// holder pin, the two tool-type pins, the change pin, a temperature and a
// current sample and the working flag. Each tick gives exactly one result on
// the m_axis channel: debounced docked position, tool type, change request,
// fault code and the display restart pulse.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata; the user must
// write it only while idle, which the block does not enforce. A write takes
// effect at the clock edge where cfg_we is high. An accepted request goes
// into the input register and its result into the result register, which
// drives m_axis. Throughput: one tick per cycle while the receiver does not
// stall; the tick's state update is one pass of comparators and small
// counters between the input register and the result register.
// Reset (arst_n low) clears the debounce, change and fault state, loads the
// default limits and empties both registers.
// When the receiver stalls, the result register holds its request, the input
// register keeps the next one, and s_tready drops only once both are full.
module tool_presence_and_fault_supervisor (
	input  logic                                clk,
	input  logic                                arst_n,
	// holder_pin[0], type_pin_a[1], type_pin_b[2], change_pin[3],
	// temp_sample[15:4], current_sample[27:16], working_mode[28], zero[31:29]
	input  logic [tpfs_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// tool_docked[0], tool_type[2:1], change_request[3], fault_code[6:4],
	// display_refresh_restart[7]
	output logic [tpfs_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic                                cfg_we,
	input  logic [tpfs_pkg::CFG_IDX_W-1:0]      cfg_addr,
	input  logic [tpfs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	tpfs_pkg::cfg_t      cfg_q;
	tpfs_pkg::state_t    state_q;
	tpfs_pkg::state_t    state_nxt;
	tpfs_pkg::in_item_t  item_s1;
	tpfs_pkg::in_item_t  item_in;
	tpfs_pkg::out_item_t res_nxt;
	tpfs_pkg::out_item_t res_s2;
	logic                valid_s1;
	logic                adv;

	// Unpack the incoming request
	assign item_in.holder_pin     = s_tdata[0];
	assign item_in.type_pin_a     = s_tdata[1];
	assign item_in.type_pin_b     = s_tdata[2];
	assign item_in.change_pin     = s_tdata[3];
	assign item_in.temp_sample    = s_tdata[15:4];
	assign item_in.current_sample = s_tdata[27:16];
	assign item_in.working_mode   = s_tdata[28];

	assign adv      = !m_tvalid || m_tready;
	assign s_tready = !valid_s1 || adv;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.temp_high_limit      <= 12'd3000;
			cfg_q.temp_absurd_limit    <= 12'd3800;
			cfg_q.temp_low_limit       <= 12'd100;
			cfg_q.fault_tick_limit     <= 16'd500;
			cfg_q.current_check_enable <= 1'b0;
			cfg_q.current_limit_type_a <= 12'd2200;
			cfg_q.current_limit_type_b <= 12'd2300;
		end else if (cfg_we) begin
			case (tpfs_pkg::reg_index_t'(cfg_addr))
				tpfs_pkg::REG_TEMP_HIGH:   cfg_q.temp_high_limit      <= cfg_wdata[11:0];
				tpfs_pkg::REG_TEMP_ABSURD: cfg_q.temp_absurd_limit    <= cfg_wdata[11:0];
				tpfs_pkg::REG_TEMP_LOW:    cfg_q.temp_low_limit       <= cfg_wdata[11:0];
				tpfs_pkg::REG_FAULT_TICKS: cfg_q.fault_tick_limit     <= cfg_wdata;
				tpfs_pkg::REG_CURRENT_EN:  cfg_q.current_check_enable <= cfg_wdata[0];
				tpfs_pkg::REG_CURRENT_A:   cfg_q.current_limit_type_a <= cfg_wdata[11:0];
				tpfs_pkg::REG_CURRENT_B:   cfg_q.current_limit_type_b <= cfg_wdata[11:0];
				default: ;
			endcase
		end
	end

	// Capture the request in the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item_in;
		end
	end

	tpfs_step u_step (
		.st   (state_q),
		.cfg  (cfg_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// Advance the supervision state and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			m_tvalid <= 1'b0;
		end else if (valid_s1 && adv) begin
			state_q  <= state_nxt;
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_tdata = {res_s2.display_refresh_restart, res_s2.fault_code,
		res_s2.change_request, res_s2.tool_type, res_s2.tool_docked};

endmodule

// ===== design/tpfs_checker.sv =====
`include "tool_presence_and_fault_supervisor_defines.svh"

module tpfs_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tready,
	input logic [tpfs_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                             m_tvalid,
	input logic                             m_tready
);

	// Stalled result holds
	`TPFS_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// With the result register empty the input side always takes a request
	`TPFS_ASSERT_IMP(a_ready, !m_tvalid, s_tready)
	// Tool type never shows the unused code
	`TPFS_ASSERT_IMP(a_type, m_tvalid, m_tdata[2:1] != 2'd3)
	// Fault code stays within the defined codes
	`TPFS_ASSERT_IMP(a_fault, m_tvalid, m_tdata[6:4] <= 3'd4)
	// The restart pulse comes only with a lifted tool
	`TPFS_ASSERT_IMP(a_pulse, m_tvalid && m_tdata[7], !m_tdata[0])

endmodule

bind tool_presence_and_fault_supervisor tpfs_checker u_tpfs_checker (.*);
